FILE: design/three_level_priority_fifo_dispatcher_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-level priority dispatcher
// Shared property wrappers; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_FIFO_DISPATCHER_CORE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_FIFO_DISPATCHER_CORE_DEFINES_SVH

// Property sampled on the rising clock, switched off while reset is applied.
`define TLPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that forbids a result strobe in the next.
`define TLPD_ASSERT_QUIET_NEXT(lbl, clk, rst_n, cond, strb, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> !(strb)) \
		else $error(msg);

`endif

FILE: design/tlpd_pkg.sv
// ----------------------------------------------------------------------------
// tlpd_pkg
// Types and fixed constants shared by the dispatcher front, queue and back.
// ----------------------------------------------------------------------------
package tlpd_pkg;

	localparam int ID_W    = 22;
	localparam int PRIO_W  = 8;
	localparam int LIMIT_W = 8;

	localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = 8'd120;
	localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 8'd130;

	typedef enum logic {
		OP_ENQ  = 1'b0,
		OP_DISP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DISP = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		LVL_HIGH = 2'd0,
		LVL_MED  = 2'd1,
		LVL_LOW  = 2'd2
	} level_t;

	typedef enum logic {
		CFG_HIGH_LIMIT   = 1'b0,
		CFG_MEDIUM_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EMIT
	} bk_state_t;

	// Classified command passed from the front to the back
	typedef struct packed {
		op_t             op;
		level_t          level;
		logic [ID_W-1:0] id;
	} cmd_t;

	// Result fields that do not depend on the queue depth
	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		level_t          level;
		logic            accepted;
		logic            last;
	} res_t;

endpackage

FILE: design/tlpd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tlpd_cmd_fifo
// Two-entry command queue between the classifying front and the back.
// ----------------------------------------------------------------------------
module tlpd_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tlpd_pkg::cmd_t  push_cmd,
	output logic            full,
	output logic            valid,
	input  logic            pop,
	output tlpd_pkg::cmd_t  head
);
	import tlpd_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign valid = (fill_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: design/tlpd_front.sv
// ----------------------------------------------------------------------------
// tlpd_front
// Accepts commands, holds the level limits and sorts each task into a level.
// ----------------------------------------------------------------------------
module tlpd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [tlpd_pkg::PRIO_W-1:0]   task_priority,
	input  logic [tlpd_pkg::ID_W-1:0]     task_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [tlpd_pkg::LIMIT_W-1:0]  cfg_data,
	input  logic                          q_full,
	output logic                          push,
	output tlpd_pkg::cmd_t                cmd
);
	import tlpd_pkg::*;

	logic [LIMIT_W-1:0] high_limit_q;
	logic [LIMIT_W-1:0] medium_limit_q;
	level_t             lvl;

	assign busy      = q_full;
	assign cfg_ready = 1'b1;
	assign push      = start && !q_full;

	// Limits are tested in order, so a medium limit below the high limit
	// leaves the medium level unreachable.
	always_comb begin
		if (task_priority < high_limit_q) begin
			lvl = LVL_HIGH;
		end else if (task_priority <= medium_limit_q) begin
			lvl = LVL_MED;
		end else begin
			lvl = LVL_LOW;
		end
	end

	assign cmd = '{op: op_t'(operation), level: lvl, id: task_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_limit_q   <= HIGH_LIMIT_RST;
			medium_limit_q <= MEDIUM_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HIGH_LIMIT:   high_limit_q   <= cfg_data;
				CFG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: design/tlpd_back.sv
// ----------------------------------------------------------------------------
// tlpd_back
// Holds the three task FIFOs; performs pushes and batched strict-order pops.
// ----------------------------------------------------------------------------
module tlpd_back #(
	parameter  int QUEUE_DEPTH = 256,
	parameter  int BATCH       = 8,
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  tlpd_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	output logic             strobe,
	output tlpd_pkg::res_t   res,
	output logic [CNT_W-1:0] high_depth,
	output logic [CNT_W-1:0] medium_depth,
	output logic [CNT_W-1:0] low_depth
);
	import tlpd_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int BCNT_W = $clog2(BATCH + 1);

	bk_state_t         state_q;
	bk_state_t         state_d;
	level_t            lvl_q;
	level_t            sel_lvl;
	logic [BCNT_W-1:0] bcnt_q;
	logic              found_q;
	logic [PTR_W-1:0]  rp_q [3];
	logic [PTR_W-1:0]  wp_q [3];
	logic [CNT_W-1:0]  cnt_q [3];
	logic [CNT_W-1:0]  cnt_d [3];
	logic [CNT_W-1:0]  depth_q [3];
	logic [CNT_W-1:0]  cnt_sel;

	logic [ID_W-1:0]   high_mem [QUEUE_DEPTH];
	logic [ID_W-1:0]   med_mem  [QUEUE_DEPTH];
	logic [ID_W-1:0]   low_mem  [QUEUE_DEPTH];
	logic [ID_W-1:0]   rd_high_q;
	logic [ID_W-1:0]   rd_med_q;
	logic [ID_W-1:0]   rd_low_q;
	logic [ID_W-1:0]   rd_sel;

	logic [2:0]        push_en;
	logic [2:0]        read_en;
	logic              room;
	logic              cur_has;
	logic              later_has;
	logic              lvl_clr;
	logic              lvl_adv;
	logic              emit;
	res_t              res_d;
	res_t              res_q;
	logic              strobe_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign sel_lvl = (state_q == BK_IDLE) ? cmd.level : lvl_q;
	assign cnt_sel = cnt_q[sel_lvl];
	assign room    = (cnt_sel != CNT_W'(QUEUE_DEPTH));
	assign cur_has = (cnt_sel != '0) && (bcnt_q < BCNT_W'(BATCH));

	assign later_has = ((lvl_q == LVL_HIGH) &&
			((cnt_q[LVL_MED] != '0) || (cnt_q[LVL_LOW] != '0))) ||
		((lvl_q == LVL_MED) && (cnt_q[LVL_LOW] != '0));

	always_comb begin
		case (lvl_q)
			LVL_HIGH: rd_sel = rd_high_q;
			LVL_MED:  rd_sel = rd_med_q;
			default:  rd_sel = rd_low_q;
		endcase
	end

	// Output decode
	always_comb begin
		cmd_pop = 1'b0;
		push_en = '0;
		read_en = '0;
		lvl_clr = 1'b0;
		lvl_adv = 1'b0;
		emit    = 1'b0;
		res_d   = '{kind: KIND_NONE, id: '0, level: LVL_HIGH, accepted: 1'b0,
			last: 1'b1};
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_ENQ) begin
						push_en[cmd.level] = room;
						emit  = 1'b1;
						res_d = '{kind: KIND_ENQ, id: cmd.id, level: cmd.level,
							accepted: room, last: 1'b1};
					end else begin
						lvl_clr = 1'b1;
					end
				end
			end
			BK_SCAN: begin
				if (cur_has) begin
					read_en[lvl_q] = 1'b1;
				end else if (lvl_q == LVL_LOW) begin
					// drained every level without a pop: answer with none
					emit = !found_q;
				end else begin
					lvl_adv = 1'b1;
				end
			end
			BK_EMIT: begin
				emit  = 1'b1;
				res_d = '{kind: KIND_DISP, id: rd_sel, level: lvl_q, accepted: 1'b0,
					last: !(cur_has || later_has)};
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && (cmd.op == OP_DISP)) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (cur_has) begin
					state_d = BK_EMIT;
				end else if (lvl_q == LVL_LOW) begin
					state_d = BK_IDLE;
				end
			end
			BK_EMIT: state_d = BK_SCAN;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			cnt_d[l] = cnt_q[l] + CNT_W'(push_en[l]) - CNT_W'(read_en[l]);
		end
	end

	// Task stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (push_en[LVL_HIGH]) begin
			high_mem[wp_q[LVL_HIGH]] <= cmd.id;
		end
		if (read_en[LVL_HIGH]) begin
			rd_high_q <= high_mem[rp_q[LVL_HIGH]];
		end
	end

	always_ff @(posedge clk) begin
		if (push_en[LVL_MED]) begin
			med_mem[wp_q[LVL_MED]] <= cmd.id;
		end
		if (read_en[LVL_MED]) begin
			rd_med_q <= med_mem[rp_q[LVL_MED]];
		end
	end

	always_ff @(posedge clk) begin
		if (push_en[LVL_LOW]) begin
			low_mem[wp_q[LVL_LOW]] <= cmd.id;
		end
		if (read_en[LVL_LOW]) begin
			rd_low_q <= low_mem[rp_q[LVL_LOW]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			lvl_q    <= LVL_HIGH;
			bcnt_q   <= '0;
			found_q  <= 1'b0;
			strobe_q <= 1'b0;
			for (int l = 0; l < 3; l++) begin
				rp_q[l]  <= '0;
				wp_q[l]  <= '0;
				cnt_q[l] <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			for (int l = 0; l < 3; l++) begin
				cnt_q[l] <= cnt_d[l];
				if (push_en[l]) begin
					wp_q[l] <= ptr_inc(wp_q[l]);
				end
				if (read_en[l]) begin
					rp_q[l] <= ptr_inc(rp_q[l]);
				end
			end
			if (lvl_clr) begin
				lvl_q   <= LVL_HIGH;
				bcnt_q  <= '0;
				found_q <= 1'b0;
			end else if (lvl_adv) begin
				lvl_q  <= level_t'(lvl_q + 2'd1);
				bcnt_q <= '0;
			end else if (read_en != '0) begin
				bcnt_q  <= bcnt_q + BCNT_W'(1);
				found_q <= 1'b1;
			end
		end
	end

	// Result register: depths are the counts after this beat's action
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
			for (int l = 0; l < 3; l++) begin
				depth_q[l] <= cnt_d[l];
			end
		end
	end

	assign strobe       = strobe_q;
	assign res          = res_q;
	assign high_depth   = depth_q[LVL_HIGH];
	assign medium_depth = depth_q[LVL_MED];
	assign low_depth    = depth_q[LVL_LOW];

endmodule

FILE: design/three_level_priority_fifo_dispatcher_core.sv
// ----------------------------------------------------------------------------
// three_level_priority_fifo_dispatcher_core
// Three strict-priority task FIFOs with classified enqueue and batched dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low.
//   operation selects enqueue (task_priority sorts task_id into high, medium
//   or low) or dispatch (pop up to BATCH ids per level, high level first).
//   Each result beat is shown for one cycle with strobe high; the receiver
//   cannot hold it off. last marks the final beat of a command.
//   The limits are written through cfg_valid/cfg_ready (ready always high),
//   index 0 high_limit, index 1 medium_limit. The user writes them only while
//   the block is idle; the block itself does not enforce this.
// Flow:
//   A command enters a two-entry queue; busy rises only while it is full.
//   Enqueue: the back end retires one enqueue per cycle while it is not busy
//   with a dispatch.
//   Dispatch: queue pop, then per popped id a store read and a result beat,
//   a step past each of the two upper levels and the closing check of the low
//   level; an empty dispatch has only the pop, the two steps and the check.
// Reset:
//   All FIFOs empty, limits 120 and 130, queue and back end idle.
// ----------------------------------------------------------------------------
`include "three_level_priority_fifo_dispatcher_core_defines.svh"

module three_level_priority_fifo_dispatcher_core #(
	parameter  int QUEUE_DEPTH = 256,
	parameter  int BATCH       = 8,
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [tlpd_pkg::PRIO_W-1:0]   task_priority,
	input  logic [tlpd_pkg::ID_W-1:0]     task_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [tlpd_pkg::LIMIT_W-1:0]  cfg_data,
	output logic                          strobe,
	output logic [1:0]                    kind,
	output logic [tlpd_pkg::ID_W-1:0]     out_task_id,
	output logic [1:0]                    level,
	output logic                          accepted,
	output logic                          last,
	output logic [CNT_W-1:0]              high_depth,
	output logic [CNT_W-1:0]              medium_depth,
	output logic [CNT_W-1:0]              low_depth
);
	import tlpd_pkg::*;

	logic q_full;
	logic q_push;
	logic q_valid;
	logic q_pop;
	cmd_t front_cmd;
	cmd_t head_cmd;
	res_t res;

	tlpd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.task_priority (task_priority),
		.task_id       (task_id),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.push          (q_push),
		.cmd           (front_cmd)
	);

	tlpd_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.head     (head_cmd)
	);

	tlpd_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.BATCH       (BATCH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.strobe       (strobe),
		.res          (res),
		.high_depth   (high_depth),
		.medium_depth (medium_depth),
		.low_depth    (low_depth)
	);

	assign kind        = res.kind;
	assign out_task_id = res.id;
	assign level       = res.level;
	assign accepted    = res.accepted;
	assign last        = res.last;

	`TLPD_ASSERT(a_none_final_empty, clk, arst_n, strobe && (kind == KIND_NONE) |-> last && (high_depth == '0) && (medium_depth == '0) && (low_depth == '0), "empty dispatch answer not final or depths not zero")
	`TLPD_ASSERT(a_enq_single_beat, clk, arst_n, strobe && (kind == KIND_ENQ) |-> last && (q_pop == 1'b0 || q_valid == 1'b1), "enqueue answer not marked last")
	`TLPD_ASSERT_QUIET_NEXT(a_burst_ends, clk, arst_n, strobe && (kind == KIND_DISP) && last, strobe, "beat follows the final dispatched id")
	`TLPD_ASSERT(a_pop_only_valid, clk, arst_n, q_pop |-> q_valid, "command queue popped while empty")

endmodule

FILE: bench/three_level_priority_fifo_dispatcher_core_tb.sv
// ----------------------------------------------------------------------------
// three_level_priority_fifo_dispatcher_core_tb
// Drives enqueue and dispatch commands, with the priority limits rewritten
// between phases. Dispatches drain the queues in batches. A
// scoreboard tracks the three task queues and checks every result beat,
// field by field and in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module three_level_priority_fifo_dispatcher_core_tb;

	import tlpd_pkg::*;

	localparam int FIFO_SLOTS  = 256;
	localparam int POP_BATCH   = 8;
	localparam int DEPTH_W     = $clog2(FIFO_SLOTS + 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 34;

	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    id;
		level_t             lvl;
		logic               accepted;
		logic               last;
		logic [DEPTH_W-1:0] high_d;
		logic [DEPTH_W-1:0] med_d;
		logic [DEPTH_W-1:0] low_d;
	} result_beat_t;

	class dispatch_scoreboard;
		logic [LIMIT_W-1:0] high_limit   = HIGH_LIMIT_RST;
		logic [LIMIT_W-1:0] medium_limit = MEDIUM_LIMIT_RST;
		logic [ID_W-1:0]    level_ids[3][$];
		result_beat_t       awaited_beats[$];
		int                 errors = 0;

		function void set_limit(cfg_idx_t idx, logic [LIMIT_W-1:0] value);
			if (idx == CFG_HIGH_LIMIT) begin
				high_limit = value;
			end else begin
				medium_limit = value;
			end
		endfunction

		function void push_beat(kind_t k, logic [ID_W-1:0] id, level_t lv, logic acc,
				logic lst);
			result_beat_t b;
			b.kind     = k;
			b.id       = id;
			b.lvl      = lv;
			b.accepted = acc;
			b.last     = lst;
			b.high_d   = DEPTH_W'(level_ids[0].size());
			b.med_d    = DEPTH_W'(level_ids[1].size());
			b.low_d    = DEPTH_W'(level_ids[2].size());
			awaited_beats.push_back(b);
		endfunction

		function void note_command(op_t op, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id);
			level_t          lv;
			logic            acc;
			int              total;
			int              n;
			logic [ID_W-1:0] popped;
			if (op == OP_ENQ) begin
				if (prio < high_limit) begin
					lv = LVL_HIGH;
				end else if (prio <= medium_limit) begin
					lv = LVL_MED;
				end else begin
					lv = LVL_LOW;
				end
				acc = (level_ids[lv].size() < FIFO_SLOTS);
				if (acc) begin
					level_ids[lv].push_back(id);
				end
				push_beat(KIND_ENQ, id, lv, acc, 1'b1);
				return;
			end
			total = 0;
			for (int l = 0; l < 3; l++) begin
				total += (level_ids[l].size() < POP_BATCH) ? level_ids[l].size() : POP_BATCH;
			end
			if (total == 0) begin
				push_beat(KIND_NONE, '0, LVL_HIGH, 1'b0, 1'b1);
				return;
			end
			n = 0;
			for (int l = 0; l < 3; l++) begin
				for (int k = 0; k < POP_BATCH && level_ids[l].size() > 0; k++) begin
					popped = level_ids[l].pop_front();
					n++;
					push_beat(KIND_DISP, popped, level_t'(l), 1'b0, n == total);
				end
			end
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [1:0] k, logic [ID_W-1:0] id, logic [1:0] lv,
				logic acc, logic lst, logic [DEPTH_W-1:0] hd, logic [DEPTH_W-1:0] md,
				logic [DEPTH_W-1:0] ld);
			result_beat_t b;
			if (awaited_beats.size() == 0) begin
				$display("%0t ns: result beat expected none, got kind %0h id %0h",
					$time, k, id);
				errors++;
				return;
			end
			b = awaited_beats.pop_front();
			compare("kind", b.kind, k);
			compare("out_task_id", b.id, id);
			compare("level", b.lvl, lv);
			compare("accepted", b.accepted, acc);
			compare("last", b.last, lst);
			compare("high_depth", b.high_d, hd);
			compare("medium_depth", b.med_d, md);
			compare("low_depth", b.low_d, ld);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [PRIO_W-1:0]   task_priority;
	logic [ID_W-1:0]     task_id;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [LIMIT_W-1:0]  cfg_data;
	logic                strobe;
	logic [1:0]          kind;
	logic [ID_W-1:0]     out_task_id;
	logic [1:0]          level;
	logic                accepted;
	logic                last;
	logic [DEPTH_W-1:0]  high_depth;
	logic [DEPTH_W-1:0]  medium_depth;
	logic [DEPTH_W-1:0]  low_depth;

	dispatch_scoreboard sb = new;
	int                 sender_idle_pct = 25;
	int                 cycle_count = 0;

	three_level_priority_fifo_dispatcher_core #(
		.QUEUE_DEPTH (FIFO_SLOTS),
		.BATCH       (POP_BATCH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.task_priority (task_priority),
		.task_id       (task_id),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.kind          (kind),
		.out_task_id   (out_task_id),
		.level         (level),
		.accepted      (accepted),
		.last          (last),
		.high_depth    (high_depth),
		.medium_depth  (medium_depth),
		.low_depth     (low_depth)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_beat(kind, out_task_id, level, accepted, last, high_depth,
				medium_depth, low_depth);
		end
	end

	// Hold start low for a random gap, then present the command until taken.
	task automatic issue(input op_t op, input logic [PRIO_W-1:0] prio,
			input logic [ID_W-1:0] id);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start         = 1'b1;
		operation     = op;
		task_priority = prio;
		task_id       = id;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sb.note_command(op, prio, id);
	endtask

	// Drop start and wait for every awaited beat, plus the tail latency.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.awaited_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input cfg_idx_t idx, input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_limit(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_high[6];
		logic [LIMIT_W-1:0] phase_med[6];
		logic [PRIO_W-1:0]  prio;
		logic [ID_W-1:0]    id;
		int                 enq_pct;

		arst_n        = 1'b0;
		start         = 1'b0;
		operation     = OP_ENQ;
		task_priority = '0;
		task_id       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_HIGH_LIMIT;
		cfg_data      = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Boundaries of the reset limits, id extremes, empty dispatch
		issue(OP_DISP, 8'd0, '0);
		issue(OP_ENQ, 8'd0, '0);
		issue(OP_ENQ, 8'd119, '1);
		issue(OP_ENQ, 8'd120, 22'h2AAAAA);
		issue(OP_ENQ, 8'd130, 22'h155555);
		issue(OP_ENQ, 8'd131, 22'h000001);
		issue(OP_ENQ, 8'd139, 22'h200000);
		issue(OP_ENQ, 8'd255, 22'h3FFFFE);
		issue(OP_DISP, 8'hFF, '1);
		issue(OP_DISP, 8'd0, '0);
		issue(OP_ENQ, 8'd200, 22'h0F0F0F);
		issue(OP_ENQ, 8'd125, 22'h30F0F0);
		issue(OP_ENQ, 8'd5, 22'h012345);
		issue(OP_DISP, 8'd0, '0);

		phase_high = '{8'd120, 8'd0, 8'd130, 8'd255, 8'd0, 8'd0};
		phase_med  = '{8'd130, 8'd255, 8'd10, 8'd255, 8'd0, 8'd0};
		phase_high[5] = LIMIT_W'($urandom_range(140));
		phase_med[5]  = LIMIT_W'($urandom_range(140));

		for (int p = 0; p < 6; p++) begin
			settle();
			write_limit(CFG_HIGH_LIMIT, phase_high[p]);
			write_limit(CFG_MEDIUM_LIMIT, phase_med[p]);
			sender_idle_pct = (p < 2) ? 25 : ((p < 4) ? 83 : 0);
			enq_pct = $urandom_range(85, 60);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Aim half the priorities at the limit edges
				case ($urandom_range(7))
					0: prio = phase_high[p] - 8'd1;
					1: prio = phase_high[p];
					2: prio = phase_med[p];
					3: prio = phase_med[p] + 8'd1;
					default: prio = PRIO_W'($urandom);
				endcase
				case ($urandom_range(9))
					0: id = '0;
					1: id = '1;
					default: id = ID_W'($urandom);
				endcase
				if ($urandom_range(99) < enq_pct) begin
					issue(OP_ENQ, prio, id);
				end else begin
					issue(OP_DISP, prio, id);
				end
			end
		end

		settle();
		if (sb.awaited_beats.size() != 0) begin
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
